// ===== sv/ppm_pkg.sv =====
// ----------------------------------------------------------------------------
// ppm_pkg: shared types and constants of the pedal plausibility monitor
// Level and scale widths, scale constants, the scale request passed to the
// shared divider, and configuration register indexes.
// ----------------------------------------------------------------------------
package ppm_pkg;

    localparam int LVL_W            = 12;
    localparam int FULL_SCALE       = 1000;
    localparam int SCALE_W          = $clog2(FULL_SCALE + 1);
    localparam int NUM_W            = LVL_W + SCALE_W;
    localparam int LIMIT_W          = 10;
    localparam int TIME_W           = 32;
    localparam int TIMEOUT_MS       = 100;
    localparam int BRAKE_ACTIVATION = 100;
    localparam int THROTTLE_ON      = 250;
    localparam int THROTTLE_OFF     = 50;
    localparam int CFG_IDX_W        = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_A_MIN       = 3'd0,
        REG_ACCEL_A_MAX       = 3'd1,
        REG_ACCEL_B_MIN       = 3'd2,
        REG_ACCEL_B_MAX       = 3'd3,
        REG_BRAKE_MIN         = 3'd4,
        REG_BRAKE_MAX         = 3'd5,
        REG_DISCONNECT_CUTOFF = 3'd6,
        REG_APPS_DIFF_LIMIT   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [LVL_W-1:0] lo;
        logic [LVL_W-1:0] hi;
        logic             brake_order;
    } scale_req_t;

endpackage

// ===== sv/ppm_scale_unit.sv =====
// ----------------------------------------------------------------------------
// ppm_scale_unit: shared clamp, multiply and restoring divide
// Clamps one reading to its window and returns
// floor((v - lo) * FULL_SCALE / (hi - lo)), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppm_scale_unit
    import ppm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  scale_req_t         req,
    output logic               done,
    output logic [SCALE_W-1:0] quo
);

    localparam int CNT_W = $clog2(SCALE_W);

    typedef enum logic [3:0] {
        SU_IDLE = 4'b0001,
        SU_LOAD = 4'b0010,
        SU_ITER = 4'b0100,
        SU_DONE = 4'b1000
    } su_state_t;

    su_state_t          state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic [NUM_W-1:0]   num_reg;
    logic [LVL_W-1:0]   div_reg;
    logic [LVL_W-1:0]   rem_reg;
    logic [SCALE_W-1:0] quo_reg;
    logic               zero_reg;

    logic [LVL_W-1:0]   clamp_lo;
    logic [LVL_W-1:0]   clamped;
    logic [LVL_W-1:0]   offset;
    logic [LVL_W-1:0]   span;
    logic [NUM_W-1:0]   product;
    logic [LVL_W:0]     trial;
    logic [LVL_W:0]     trial_diff;
    logic               trial_ge;

    // clamp order differs between pedal and brake
    always_comb
    begin
        if (req.brake_order)
        begin
            clamp_lo = (req.level > req.hi) ? req.hi : req.level;
            clamped  = (clamp_lo < req.lo) ? req.lo : clamp_lo;
        end
        else
        begin
            clamp_lo = (req.level < req.lo) ? req.lo : req.level;
            clamped  = (clamp_lo > req.hi) ? req.hi : clamp_lo;
        end
        offset  = clamped - req.lo;
        span    = req.hi - req.lo;
        product = NUM_W'(offset) * NUM_W'(FULL_SCALE);
    end

    always_comb
    begin
        trial      = {rem_reg, num_reg[SCALE_W-1]};
        trial_diff = trial - {1'b0, div_reg};
        trial_ge   = (trial >= {1'b0, div_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            SU_IDLE:
            begin
                if (start)
                begin
                    state_next = SU_LOAD;
                end
            end
            SU_LOAD:
            begin
                cnt_next   = '0;
                state_next = SU_ITER;
            end
            SU_ITER:
            begin
                if (cnt_reg == CNT_W'(SCALE_W - 1))
                begin
                    state_next = SU_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            SU_DONE:
            begin
                state_next = SU_IDLE;
            end
            default:
            begin
                state_next = SU_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SU_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == SU_IDLE && start)
        begin
            num_reg  <= product;
            div_reg  <= span;
            zero_reg <= (req.hi <= req.lo);
        end
        else if (state_reg == SU_LOAD)
        begin
            // quotient fits SCALE_W bits, so the top part is already below the divisor
            rem_reg <= num_reg[NUM_W-1:SCALE_W];
        end
        else if (state_reg == SU_ITER)
        begin
            rem_reg <= trial_ge ? trial_diff[LVL_W-1:0] : trial[LVL_W-1:0];
            quo_reg <= {quo_reg[SCALE_W-2:0], trial_ge};
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
        end
    end

    assign done = (state_reg == SU_DONE);
    assign quo  = zero_reg ? '0 : quo_reg;

endmodule

// ===== sv/ppm_fault_timer.sv =====
// ----------------------------------------------------------------------------
// ppm_fault_timer: fault persistence timer
// Records the time of the first faulty sample and latches the kill flag
// once the fault has lasted longer than TIMEOUT_MS.
// ----------------------------------------------------------------------------
module ppm_fault_timer
    import ppm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              fault,
    input  logic [TIME_W-1:0] now,
    output logic              kill
);

    logic              timing_reg, timing_next;
    logic [TIME_W-1:0] since_reg, since_next;
    logic              latched_reg, latched_next;

    logic [TIME_W-1:0] since_eff;
    logic [TIME_W-1:0] elapsed;
    logic              over;

    always_comb
    begin
        since_eff    = timing_reg ? since_reg : now;
        elapsed      = now - since_eff;
        over         = (elapsed > TIME_W'(TIMEOUT_MS));
        timing_next  = timing_reg;
        since_next   = since_reg;
        latched_next = latched_reg;
        if (en)
        begin
            if (fault)
            begin
                timing_next  = 1'b1;
                since_next   = since_eff;
                latched_next = latched_reg | over;
            end
            else
            begin
                timing_next  = 1'b0;
                since_next   = '0;
                latched_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg  <= 1'b0;
            since_reg   <= '0;
            latched_reg <= 1'b0;
        end
        else
        begin
            timing_reg  <= timing_next;
            since_reg   <= since_next;
            latched_reg <= latched_next;
        end
    end

    assign kill = latched_reg;

endmodule

// ===== sv/pedal_plausibility_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// pedal_plausibility_monitor_unit: accelerator and brake plausibility check
// Scales three readings through one shared divider, checks accelerator
// agreement and sensor disconnects, times faults and latches kill flags.
//
//   channel  direction  width  contents
//   s_*      in         72     accel_a_level, accel_b_level, brake_level, now_ms
//   m_*      out        40     three scaled values, five fault and kill flags
//   cfg_*    in         12     register write, index on cfg_addr
//
// each item runs through the shared divider from one accepted transfer to the
// next: a start, a load, 10 quotient steps and a done for each of the three
// readings, then an evaluate, a send and an idle state; input waits for idle
// the result sits in an output register; a stalled result holds the
// sequencer in its send state until taken
// reset clears the registers to their defaults and all fault timers
// ----------------------------------------------------------------------------
module pedal_plausibility_monitor_unit
    import ppm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // accel_a_level[11:0], accel_b_level[23:12], brake_level[35:24],
    // now_ms[67:36], zero fill
    input  logic [71:0]          s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // accel_a_scaled[9:0], accel_b_scaled[19:10], brake_scaled[29:20],
    // apps_fault_now[30], apps_kill[31], bse_fault_now[32], bse_kill[33],
    // overlap_kill[34], zero fill
    output logic [39:0]          m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [LVL_W-1:0]     cfg_wdata
);

    localparam int CMP_W = (SCALE_W > LIMIT_W) ? SCALE_W : LIMIT_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_START = 5'b00010,
        ST_WAIT  = 5'b00100,
        ST_EVAL  = 5'b01000,
        ST_SEND  = 5'b10000
    } ctl_state_t;

    typedef enum logic [1:0] {
        CH_A     = 2'd0,
        CH_B     = 2'd1,
        CH_BRAKE = 2'd2
    } channel_t;

    ctl_state_t         state_reg, state_next;
    channel_t           ch_reg, ch_next;

    logic [LVL_W-1:0]   amin_reg, amax_reg, bmin_reg, bmax_reg;
    logic [LVL_W-1:0]   rmin_reg, rmax_reg, cutoff_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic [LVL_W-1:0]   lvl_a_reg, lvl_b_reg, lvl_br_reg;
    logic [TIME_W-1:0]  now_reg;

    logic [SCALE_W-1:0] sa_reg, sb_reg, sr_reg;
    logic               apps_fault_reg, bse_fault_reg, overlap_reg, overlap_next;

    logic               m_tvalid_reg;
    logic [39:0]        m_tdata_reg;

    scale_req_t         su_req;
    logic               su_start;
    logic               su_done;
    logic [SCALE_W-1:0] su_quo;

    logic [SCALE_W-1:0] diff;
    logic               apps_fault, bse_fault, ov_set, ov_hold;
    logic               eval_en;
    logic               apps_kill, bse_kill;
    logic               out_load;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amin_reg   <= '0;
            amax_reg   <= '1;
            bmin_reg   <= '0;
            bmax_reg   <= '1;
            rmin_reg   <= '0;
            rmax_reg   <= '1;
            cutoff_reg <= LVL_W'(100);
            limit_reg  <= LIMIT_W'(100);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_ACCEL_A_MIN:       amin_reg   <= cfg_wdata;
                REG_ACCEL_A_MAX:       amax_reg   <= cfg_wdata;
                REG_ACCEL_B_MIN:       bmin_reg   <= cfg_wdata;
                REG_ACCEL_B_MAX:       bmax_reg   <= cfg_wdata;
                REG_BRAKE_MIN:         rmin_reg   <= cfg_wdata;
                REG_BRAKE_MAX:         rmax_reg   <= cfg_wdata;
                REG_DISCONNECT_CUTOFF: cutoff_reg <= cfg_wdata;
                REG_APPS_DIFF_LIMIT:   limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                default:               ;
            endcase
        end
    end

    // operand select for the shared divider
    always_comb
    begin
        unique case (ch_reg)
            CH_A:     su_req = '{level: lvl_a_reg, lo: amin_reg, hi: amax_reg,
                                 brake_order: 1'b0};
            CH_B:     su_req = '{level: lvl_b_reg, lo: bmin_reg, hi: bmax_reg,
                                 brake_order: 1'b0};
            CH_BRAKE: su_req = '{level: lvl_br_reg, lo: rmin_reg, hi: rmax_reg,
                                 brake_order: 1'b1};
            default:  su_req = '{level: lvl_a_reg, lo: amin_reg, hi: amax_reg,
                                 brake_order: 1'b0};
        endcase
    end

    assign su_start = (state_reg == ST_START);

    ppm_scale_unit u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .start (su_start),
        .req   (su_req),
        .done  (su_done),
        .quo   (su_quo)
    );

    // plausibility checks
    always_comb
    begin
        diff       = (sa_reg >= sb_reg) ? (sa_reg - sb_reg) : (sb_reg - sa_reg);
        apps_fault = (lvl_a_reg < cutoff_reg) || (lvl_b_reg < cutoff_reg) ||
                     (CMP_W'(diff) > CMP_W'(limit_reg));
        bse_fault  = (lvl_br_reg < cutoff_reg);
        ov_set     = (sr_reg > SCALE_W'(BRAKE_ACTIVATION)) &&
                     (sa_reg > SCALE_W'(THROTTLE_ON));
        ov_hold    = overlap_reg | ov_set;
        overlap_next = ov_hold && !(sa_reg < SCALE_W'(THROTTLE_OFF));
    end

    assign eval_en = (state_reg == ST_EVAL);

    ppm_fault_timer u_apps_timer (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (eval_en),
        .fault (apps_fault),
        .now   (now_reg),
        .kill  (apps_kill)
    );

    ppm_fault_timer u_bse_timer (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (eval_en),
        .fault (bse_fault),
        .now   (now_reg),
        .kill  (bse_kill)
    );

    assign out_load = (state_reg == ST_SEND) && (!m_tvalid_reg || m_tready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ch_next    = CH_A;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (su_done)
                begin
                    if (ch_reg == CH_BRAKE)
                    begin
                        state_next = ST_EVAL;
                    end
                    else
                    begin
                        ch_next    = (ch_reg == CH_A) ? CH_B : CH_BRAKE;
                        state_next = ST_START;
                    end
                end
            end
            ST_EVAL:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ch_reg       <= CH_A;
            overlap_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            if (eval_en)
            begin
                overlap_reg <= overlap_next;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            lvl_a_reg  <= s_tdata[11:0];
            lvl_b_reg  <= s_tdata[23:12];
            lvl_br_reg <= s_tdata[35:24];
            now_reg    <= s_tdata[67:36];
        end
        if (state_reg == ST_WAIT && su_done)
        begin
            case (ch_reg)
                CH_A:     sa_reg <= su_quo;
                CH_B:     sb_reg <= SCALE_W'(FULL_SCALE) - su_quo;
                default:  sr_reg <= su_quo;
            endcase
        end
        if (eval_en)
        begin
            apps_fault_reg <= apps_fault;
            bse_fault_reg  <= bse_fault;
        end
        if (out_load)
        begin
            m_tdata_reg <= {5'b0, overlap_reg, bse_kill, bse_fault_reg, apps_kill,
                            apps_fault_reg, sr_reg, sb_reg, sa_reg};
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_start_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_START && ch_reg == CH_A))
        else $error("sequencer did not start on the first reading");

    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        su_done |-> (state_reg == ST_WAIT))
        else $error("divider finished outside the wait state");

    a_quotient_range: assert property (@(posedge clk) disable iff (!rst_n)
        su_done |-> (su_quo <= SCALE_W'(FULL_SCALE)))
        else $error("scaled value above full scale");

    a_kill_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND) |-> ((!apps_kill || apps_fault_reg) &&
                                    (!bse_kill || bse_fault_reg)))
        else $error("kill flag set without a present fault");

    a_overlap_throttle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND) |-> (!overlap_reg || sa_reg >= SCALE_W'(THROTTLE_OFF)))
        else $error("overlap latch held with throttle released");
`endif

endmodule
